>>> design/hkbr_pkg.sv
// Shared types and constants for the HID keyboard boot report builder.
// No dependencies; every other design file imports this package.
package hkbr_pkg;

	// Key slot count and derived counter width
	localparam int KEY_SLOTS = 6;
	localparam int HELD_W    = $clog2(KEY_SLOTS + 1);
	localparam int OUT_KEYS  = 6;

	// Command queue geometry
	localparam int CQ_DEPTH = 4;
	localparam int CQ_AW    = $clog2(CQ_DEPTH);
	localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

	// HID codes
	localparam logic [15:0] PAGE_KEYBOARD = 16'h0007;
	localparam logic [15:0] MOD_FIRST     = 16'h00E0;
	localparam logic [15:0] MOD_LAST      = 16'h00E7;
	localparam logic [15:0] KEY_MAX       = 16'h00FF;
	localparam logic [7:0]  ROLLOVER_CODE = 8'h01;
	localparam logic [7:0]  KEY_NONE      = 8'h00;

	typedef struct packed {
		logic [15:0]        hid_page;
		logic [15:0]        usage;
		logic signed [31:0] field_value;
		logic               last_field;
	} item_t;

	typedef struct packed {
		logic [7:0] modifier_bits;
		logic [7:0] key_a;
		logic [7:0] key_b;
		logic [7:0] key_c;
		logic [7:0] key_d;
		logic [7:0] key_e;
		logic [7:0] key_f;
	} report_t;

	// Field classes produced by the front end
	typedef enum logic [2:0] {
		CMD_OTHER,   // not on the keyboard page
		CMD_PAGE,    // keyboard page, adds nothing
		CMD_MOD,     // modifier usage
		CMD_KEY,     // key usage to place in a slot
		CMD_ROLL     // usage above the key range
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] code;
		logic       last;
	} cmd_t;

	// Write side of the command queue
	typedef struct packed {
		logic wr_en;
		cmd_t wr_cmd;
	} cq_wr_t;

	// Read side of the command queue
	typedef struct packed {
		logic rd_valid;
		cmd_t rd_cmd;
	} cq_rd_t;

endpackage

>>> design/hkbr_front.sv
// Front end: accepts input beats and classifies each field into a command.
// Depends on hkbr_pkg.
module hkbr_front import hkbr_pkg::*; (
	input  item_t  item,
	input  logic   push,
	output logic   full,
	input  logic   cq_full,
	output cq_wr_t cq_wr
);

	cmd_t cmd;

	// Classify the field by page, value and usage range
	always_comb begin
		cmd.kind = CMD_OTHER;
		cmd.code = item.usage[7:0];
		cmd.last = item.last_field;
		if (item.hid_page != PAGE_KEYBOARD) begin
			cmd.kind = CMD_OTHER;
		end else if (item.field_value == 32'sd0) begin
			cmd.kind = CMD_PAGE;
		end else if (item.usage >= MOD_FIRST && item.usage <= MOD_LAST) begin
			cmd.kind = CMD_MOD;
		end else if (item.usage > KEY_MAX) begin
			cmd.kind = CMD_ROLL;
		end else if (item.usage[7:0] == KEY_NONE) begin
			cmd.kind = CMD_PAGE;
		end else begin
			cmd.kind = CMD_KEY;
		end
	end

	// Hand the command to the queue on every accepted beat
	assign full         = cq_full;
	assign cq_wr.wr_en  = push && !cq_full;
	assign cq_wr.wr_cmd = cmd;

endmodule

>>> design/hkbr_cmd_queue.sv
// Short command queue that decouples the front end from the accumulator.
// Depends on hkbr_pkg.
module hkbr_cmd_queue import hkbr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cq_wr_t cq_wr,
	output logic   cq_full,
	output cq_rd_t cq_rd,
	input  logic   rd_en
);

	cmd_t             entry_q [CQ_DEPTH];
	logic [CQ_AW-1:0] wr_ptr_q;
	logic [CQ_AW-1:0] rd_ptr_q;
	logic [CQ_CW-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign cq_full        = (count_q == CQ_CW'(CQ_DEPTH));
	assign cq_rd.rd_valid = (count_q != '0);
	assign cq_rd.rd_cmd   = entry_q[rd_ptr_q];
	assign do_wr          = cq_wr.wr_en && !cq_full;
	assign do_rd          = rd_en && cq_rd.rd_valid;

	// Store commands
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= cq_wr.wr_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> design/hkbr_back.sv
// Back end: accumulates modifiers and key slots, builds boot reports and
// buffers them for the result side. Depends on hkbr_pkg.
module hkbr_back import hkbr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cq_rd_t  cq_rd,
	output logic    rd_en,
	output report_t result,
	output logic    empty,
	input  logic    pop
);

	// Accumulator
	logic [7:0]        mod_q;
	logic [7:0]        slot_q [KEY_SLOTS];
	logic [HELD_W-1:0] held_q;
	logic              seen_q;
	logic              ovf_q;

	logic [7:0]        mod_n;
	logic [7:0]        slot_n [KEY_SLOTS];
	logic [HELD_W-1:0] held_n;
	logic              seen_n;
	logic              ovf_n;
	logic              hit;

	// Result buffer, two entries
	report_t           res_q [2];
	logic              rd_ptr_q;
	logic [1:0]        ocnt_q;
	logic              wr_ptr;

	logic              out_pop;
	logic              consume;
	logic              emit;
	cmd_t              cmd;
	logic [7:0]        keys [OUT_KEYS];
	report_t           report;

	assign cmd     = cq_rd.rd_cmd;
	assign empty   = (ocnt_q == 2'd0);
	assign result  = res_q[rd_ptr_q];
	assign out_pop = pop && !empty;
	assign consume = cq_rd.rd_valid && (ocnt_q != 2'd2 || out_pop);
	assign rd_en   = consume;
	assign emit    = consume && cmd.last && seen_n;
	assign wr_ptr  = rd_ptr_q ^ ocnt_q[0];

	// Compare the code against every held slot in parallel
	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (HELD_W'(i) < held_q && slot_q[i] == cmd.code) begin
				hit = 1'b1;
			end
		end
	end

	// Apply one command to the accumulator
	always_comb begin
		mod_n  = mod_q;
		held_n = held_q;
		ovf_n  = ovf_q;
		seen_n = seen_q || (cmd.kind != CMD_OTHER);
		for (int i = 0; i < KEY_SLOTS; i++) begin
			slot_n[i] = slot_q[i];
		end
		case (cmd.kind)
			CMD_MOD: begin
				mod_n = mod_q | (8'd1 << cmd.code[2:0]);
			end
			CMD_ROLL: begin
				ovf_n = 1'b1;
			end
			CMD_KEY: begin
				if (!hit) begin
					if (held_q < HELD_W'(KEY_SLOTS)) begin
						for (int i = 0; i < KEY_SLOTS; i++) begin
							if (held_q == HELD_W'(i)) begin
								slot_n[i] = cmd.code;
							end
						end
						held_n = held_q + 1'b1;
					end else begin
						ovf_n = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Map slots to the six report key fields
	for (genvar j = 0; j < OUT_KEYS; j++) begin : g_key
		if (j < KEY_SLOTS) begin : g_slot
			assign keys[j] = ovf_n ? ROLLOVER_CODE : slot_n[j];
		end else begin : g_pad
			assign keys[j] = ovf_n ? ROLLOVER_CODE : KEY_NONE;
		end
	end

	always_comb begin
		report.modifier_bits = mod_n;
		report.key_a         = keys[0];
		report.key_b         = keys[1];
		report.key_c         = keys[2];
		report.key_d         = keys[3];
		report.key_e         = keys[4];
		report.key_f         = keys[5];
	end

	// Update the accumulator; clear it after the last field
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q  <= '0;
			held_q <= '0;
			seen_q <= 1'b0;
			ovf_q  <= 1'b0;
			for (int i = 0; i < KEY_SLOTS; i++) begin
				slot_q[i] <= '0;
			end
		end else if (consume) begin
			if (cmd.last) begin
				mod_q  <= '0;
				held_q <= '0;
				seen_q <= 1'b0;
				ovf_q  <= 1'b0;
				for (int i = 0; i < KEY_SLOTS; i++) begin
					slot_q[i] <= '0;
				end
			end else begin
				mod_q  <= mod_n;
				held_q <= held_n;
				seen_q <= seen_n;
				ovf_q  <= ovf_n;
				for (int i = 0; i < KEY_SLOTS; i++) begin
					slot_q[i] <= slot_n[i];
				end
			end
		end
	end

	// Store finished reports
	always_ff @(posedge clk) begin
		if (emit) begin
			res_q[wr_ptr] <= report;
		end
	end

	// Track result buffer occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			ocnt_q   <= 2'd0;
		end else begin
			if (out_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({emit, out_pop})
				2'b10:   ocnt_q <= ocnt_q + 2'd1;
				2'b01:   ocnt_q <= ocnt_q - 2'd1;
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

	// Buffer never overfills
	a_ocnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q != 2'd3)
		else $error("result buffer count out of range");

	// Slot count never passes the slot total
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= HELD_W'(KEY_SLOTS))
		else $error("held key count out of range");

	// Last field clears the accumulator
	a_clear_last: assert property (@(posedge clk) disable iff (!arst_n)
		consume && cmd.last |=> held_q == '0 && !seen_q && !ovf_q && mod_q == '0)
		else $error("accumulator not cleared after last field");

	// A report lands in the buffer on emit
	a_emit_fill: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !out_pop |=> !empty)
		else $error("emitted report missing from buffer");

endmodule

>>> design/hid_keyboard_boot_report_builder_top.sv
// Top level of the HID keyboard boot report builder.
// Depends on hkbr_pkg, hkbr_front, hkbr_cmd_queue and hkbr_back.

// Accepts one parsed HID field per clock unless full, and returns one
// 8-byte-style boot report (modifiers plus six key slots) for each report
// whose fields include at least one keyboard-page field. Sustained rate is
// one field per cycle while the result buffer has room: the accumulator
// applies one field per clock unless stalled, with all six duplicate
// compares done in parallel. A report's last field is registered in the
// four-entry command queue between classifier and accumulator, then the
// report in the two-entry result buffer, which lets fields keep flowing
// while a report waits to be popped; with two reports waiting, the
// accumulator stalls and the input fills after at most four more fields.
module hid_keyboard_boot_report_builder_top import hkbr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  logic    push,
	output logic    full,
	output report_t result,
	output logic    empty,
	input  logic    pop
);

	cq_wr_t cq_wr;
	cq_rd_t cq_rd;
	logic   cq_full;
	logic   rd_en;

	hkbr_front u_front (
		.item    (item),
		.push    (push),
		.full    (full),
		.cq_full (cq_full),
		.cq_wr   (cq_wr)
	);

	hkbr_cmd_queue u_cmd_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.cq_wr   (cq_wr),
		.cq_full (cq_full),
		.cq_rd   (cq_rd),
		.rd_en   (rd_en)
	);

	hkbr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cq_rd  (cq_rd),
		.rd_en  (rd_en),
		.result (result),
		.empty  (empty),
		.pop    (pop)
	);

endmodule

>>> test/hkbr_report_checker.sv
// Checker for the HID keyboard boot report builder: watches both queue sides,
// predicts each boot report and compares it. Depends on hkbr_pkg.
module hkbr_report_checker import hkbr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  logic    push,
	input  logic    full,
	input  report_t result,
	input  logic    empty,
	input  logic    pop,
	output int      fail_count,
	output int      pending_reports
);
	timeunit 1ns;
	timeprecision 1ps;

	// Report being gathered from the accepted fields
	logic [7:0] kb_mods = '0;
	logic [7:0] kb_keys [KEY_SLOTS];
	int         kb_used = 0;
	bit         kb_page_seen = 0;
	bit         kb_rollover = 0;

	report_t expected_reports [$];
	int      faults = 0;
	int      waiting = 0;

	assign fail_count = faults;
	assign pending_reports = waiting;

	task automatic flag_fault(input string msg);
		$display("%t mismatch: %s", $realtime, msg);
		faults++;
	endtask

	task automatic check_byte(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			flag_fault($sformatf("%s got %02h want %02h", name, got, want));
	endtask

	task automatic clear_report_state();
		kb_mods = '0;
		foreach (kb_keys[i]) kb_keys[i] = KEY_NONE;
		kb_used = 0;
		kb_page_seen = 0;
		kb_rollover = 0;
	endtask

	// Fold one field into the report and queue the report on the last field
	task automatic absorb_field(input item_t f);
		bit         known;
		logic [7:0] code;
		logic [7:0] slot_out [OUT_KEYS];
		report_t    rep;
		known = 0;
		code = f.usage[7:0];
		if (f.hid_page == PAGE_KEYBOARD) begin
			kb_page_seen = 1;
			if (f.field_value != 0) begin
				if (f.usage >= MOD_FIRST && f.usage <= MOD_LAST) begin
					kb_mods[f.usage[2:0]] = 1'b1;
				end else if (f.usage > KEY_MAX) begin
					kb_rollover = 1;
				end else if (code != KEY_NONE) begin
					for (int i = 0; i < kb_used; i++)
						if (kb_keys[i] == code) known = 1;
					if (!known) begin
						if (kb_used >= KEY_SLOTS) begin
							kb_rollover = 1;
						end else begin
							kb_keys[kb_used] = code;
							kb_used++;
						end
					end
				end
			end
		end
		if (f.last_field) begin
			if (kb_page_seen) begin
				for (int j = 0; j < OUT_KEYS; j++) begin
					if (kb_rollover) slot_out[j] = ROLLOVER_CODE;
					else if (j < KEY_SLOTS) slot_out[j] = kb_keys[j];
					else slot_out[j] = KEY_NONE;
				end
				rep.modifier_bits = kb_mods;
				rep.key_a = slot_out[0];
				rep.key_b = slot_out[1];
				rep.key_c = slot_out[2];
				rep.key_d = slot_out[3];
				rep.key_e = slot_out[4];
				rep.key_f = slot_out[5];
				expected_reports.push_back(rep);
			end
			clear_report_state();
		end
	endtask

	// Compare each popped beat, then predict from each pushed beat
	always @(posedge clk or negedge arst_n) begin
		report_t want;
		if (!arst_n) begin
			clear_report_state();
			expected_reports.delete();
		end else begin
			if (pop && !empty) begin
				if (expected_reports.size() == 0) begin
					flag_fault("report popped with none expected");
				end else begin
					want = expected_reports.pop_front();
					check_byte("modifier_bits", result.modifier_bits, want.modifier_bits);
					check_byte("key_a", result.key_a, want.key_a);
					check_byte("key_b", result.key_b, want.key_b);
					check_byte("key_c", result.key_c, want.key_c);
					check_byte("key_d", result.key_d, want.key_d);
					check_byte("key_e", result.key_e, want.key_e);
					check_byte("key_f", result.key_f, want.key_f);
				end
			end
			if (push && !full)
				absorb_field(item);
		end
		waiting = expected_reports.size();
	end

endmodule

>>> test/tb_hid_keyboard_boot_report_builder_top.sv
// Testbench top for the HID keyboard boot report builder: drives HID fields, pops
// reports, gives the verdict. Depends on hkbr_pkg, hkbr_report_checker and the DUT.
module tb_hid_keyboard_boot_report_builder_top;
	timeunit 1ns;
	timeprecision 1ps;
	import hkbr_pkg::*;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	item_t   item = '0;
	logic    push = 1'b0;
	logic    full;
	report_t result;
	logic    empty;
	logic    pop = 1'b0;
	int      fail_count;
	int      pending_reports;

	bit tx_idle = 1;
	bit rx_idle = 1;
	bit hold_req = 0;
	int sent_items = 0;

	hid_keyboard_boot_report_builder_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.push(push),
		.full(full),
		.result(result),
		.empty(empty),
		.pop(pop)
	);

	hkbr_report_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.push(push),
		.full(full),
		.result(result),
		.empty(empty),
		.pop(pop),
		.fail_count(fail_count),
		.pending_reports(pending_reports)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Bound the run
	initial begin
		#3000000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic item_t mk_field(input logic [15:0] page, input logic [15:0] usage,
			input logic [31:0] value, input logic last);
		item_t f;
		f.hid_page = page;
		f.usage = usage;
		f.field_value = value;
		f.last_field = last;
		return f;
	endfunction

	function automatic item_t kf(input logic [15:0] usage, input logic [31:0] value,
			input logic last);
		return mk_field(PAGE_KEYBOARD, usage, value, last);
	endfunction

	// Draw one field; noise fields take any page and usage
	function automatic item_t pick_field(input bit noise, input bit last);
		logic [15:0] page;
		logic [15:0] usage;
		logic [31:0] value;
		int          r;
		r = $urandom_range(0, 99);
		if (r < 45) usage = 16'h0004 + 16'($urandom_range(0, 9));
		else if (r < 65) usage = 16'($urandom_range(0, 255));
		else if (r < 80) usage = MOD_FIRST + 16'($urandom_range(0, 7));
		else if (r < 87) usage = 16'h0000;
		else if (r < 95) usage = 16'($urandom_range(16'h0100, 16'hFFFF));
		else usage = 16'($urandom);
		value = $urandom;
		if (value == 0) value = 1;
		if ($urandom_range(0, 9) < 3) value = 0;
		page = ($urandom_range(0, 9) == 0) ? 16'($urandom) : PAGE_KEYBOARD;
		if (noise) begin
			page = ($urandom_range(0, 3) == 0) ? PAGE_KEYBOARD : 16'($urandom);
			usage = 16'($urandom);
			value = $urandom;
		end
		return mk_field(page, usage, value, last);
	endfunction

	// Offer one beat, with an optional idle burst first, and hold until taken
	task automatic put_field(input item_t f);
		if (tx_idle && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		push <= 1'b1;
		item <= f;
		sent_items++;
		do @(posedge clk); while (full);
	endtask

	task automatic go_quiet();
		@(negedge clk);
		push <= 1'b0;
	endtask

	task automatic send_report(input bit noise);
		int n;
		n = $urandom_range(1, 10);
		for (int i = 0; i < n; i++)
			put_field(pick_field(noise, i == n - 1));
	endtask

	task automatic random_reports(input int target);
		while (sent_items < target)
			send_report($urandom_range(0, 6) == 0);
	endtask

	// Receiver: long hold on request, random stall bursts, otherwise pop
	initial begin
		forever begin
			if (hold_req) begin
				hold_req = 0;
				pop <= 1'b0;
				repeat (120) @(negedge clk);
			end else if (rx_idle && $urandom_range(0, 3) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end else begin
				pop <= 1'b1;
				@(negedge clk);
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Other page only: no report
		put_field(mk_field(16'h0001, 16'h0004, 32'h1, 1'b1));
		// Keyboard page with zero value: empty report
		put_field(kf(16'h0004, 32'h0, 1'b1));
		// Outer modifiers, duplicate key, usage zero, top key code
		put_field(kf(MOD_FIRST, 32'h1, 1'b0));
		put_field(kf(MOD_LAST, 32'hFFFF_FFFF, 1'b0));
		put_field(kf(16'h0004, 32'h1, 1'b0));
		put_field(kf(16'h0004, 32'h5, 1'b0));
		put_field(kf(16'h0000, 32'h1, 1'b0));
		put_field(kf(16'h00FF, 32'h7FFF_FFFF, 1'b1));
		// Fill all slots, then one distinct key more
		for (int k = 0; k < KEY_SLOTS; k++)
			put_field(kf(16'h0004 + 16'(k), (k % 2) ? 32'h8000_0000 : 32'h1, 1'b0));
		put_field(kf(16'h000A, 32'h1, 1'b0));
		put_field(kf(MOD_FIRST + 16'h3, 32'h1, 1'b1));
		// Usage above the key range; last field on another page still reports
		put_field(kf(16'h0100, 32'h1, 1'b0));
		put_field(kf(16'h0005, 32'h1, 1'b0));
		put_field(mk_field(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
		// Near-miss pages only: no report; then one keyboard field above the key range
		put_field(mk_field(16'h0107, MOD_FIRST + 16'h1, 32'h1, 1'b0));
		put_field(mk_field(16'h0000, 16'h0000, 32'h0, 1'b1));
		put_field(kf(16'hFFFF, 32'h1, 1'b1));

		random_reports(500);

		// Hold off the receiver while one-field reports keep coming
		tx_idle = 0;
		hold_req = 1;
		for (int k = 0; k < 40; k++)
			put_field(kf(16'h0004 + 16'(k % 8), 32'h1, 1'b1));
		tx_idle = 1;

		// Pause the sender until every report is out
		go_quiet();
		wait (pending_reports == 0);

		random_reports(1000);

		// No idling on either side to the end
		tx_idle = 0;
		rx_idle = 0;
		random_reports(1150);
		go_quiet();

		wait (pending_reports == 0);
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending_reports == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

>>> files.f
design/hkbr_pkg.sv
design/hkbr_front.sv
design/hkbr_cmd_queue.sv
design/hkbr_back.sv
design/hid_keyboard_boot_report_builder_top.sv
test/hkbr_report_checker.sv
test/tb_hid_keyboard_boot_report_builder_top.sv
